@@ design/acdb_pkg.sv @@
// shared constants and codes for the command descriptor builder
package acdb_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int BYTE_COUNT_W = 13;

    localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
    localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NO_SLOT = 2'd1,
        STATUS_BAD_CNT = 2'd2
    } status_t;

endpackage

@@ design/acdb_req_if.sv @@
// request channel: one command per word
interface acdb_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [47:0] lba;
    logic [15:0] sector_count;
    logic [31:0] buffer_address;
    logic [31:0] busy_slots;

    modport source (output valid, cmd, lba, sector_count, buffer_address, busy_slots,
                    input ready);
    modport sink   (input valid, cmd, lba, sector_count, buffer_address, busy_slots,
                    output ready);
endinterface

@@ design/acdb_rsp_if.sv @@
// result channel: one scatter-gather entry per word
interface acdb_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [4:0]  slot;
    logic        write_dir;
    logic [7:0]  ata_command;
    logic [3:0]  entry_total;
    logic [2:0]  entry_index;
    logic [31:0] data_address;
    logic [12:0] byte_count_less_one;
    logic        irq_on_done;
    logic [47:0] fis_lba;
    logic [15:0] fis_count;
    logic        last;

    modport source (output valid, status, slot, write_dir, ata_command, entry_total,
                    entry_index, data_address, byte_count_less_one, irq_on_done,
                    fis_lba, fis_count, last,
                    input ready);
    modport sink   (input valid, status, slot, write_dir, ata_command, entry_total,
                    entry_index, data_address, byte_count_less_one, irq_on_done,
                    fis_lba, fis_count, last,
                    output ready);
endinterface

@@ design/ahci_command_descriptor_builder_unit.sv @@
// top level: builds slot choice and scatter-gather entries for one command
//
// channel | dir | word
// req     | in  | cmd, lba, sector_count, buffer_address, busy_slots
// rsp     | out | status, slot, header bits, one scatter-gather entry, fis fields
//
// a command of n entries is taken, then its slot and count are checked, then n passes of
// the shared remaining-count subtractor size the table, then n more through the same
// subtractor emit the entries, one entry per cycle while rsp does not stall.
// an error command yields one word.
// rsp stalls hold the sequencer in the check or emit step; req is taken only when idle.
// rst_n clears the sequencer and the output valid at once.
module ahci_command_descriptor_builder_unit #(
    parameter int MAX_ENTRIES       = 8,
    parameter int SECTORS_PER_ENTRY = 16,
    parameter int NUM_SLOTS         = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    acdb_req_if.sink     req,
    acdb_rsp_if.source   rsp
);

    localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [15:0] SPE          = 16'(SECTORS_PER_ENTRY);
    localparam logic [15:0] SECTOR_LIMIT = 16'(MAX_ENTRIES * SECTORS_PER_ENTRY);
    localparam logic [31:0] STRIDE       = 32'(SECTORS_PER_ENTRY * acdb_pkg::SECTOR_BYTES);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CHECK = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  slot;
        logic        write_dir;
        logic [7:0]  ata_command;
        logic [3:0]  entry_total;
        logic [2:0]  entry_index;
        logic [31:0] data_address;
        logic [12:0] byte_count_less_one;
        logic        irq_on_done;
        logic [47:0] fis_lba;
        logic [15:0] fis_count;
        logic        last;
    } rsp_word_t;

    state_t            state_reg, state_next;
    logic              out_valid_reg, out_valid_next;
    rsp_word_t         out_reg, out_next;
    logic              out_load;
    logic              out_free;

    logic              dir_reg;
    logic [47:0]       lba_reg;
    logic [15:0]       count_reg;
    logic [31:0]       addr_reg, addr_next;
    logic [4:0]        slot_reg;
    logic              found_reg;
    logic [15:0]       rem_reg, rem_next;
    logic [ENT_W-1:0]  ent_reg, ent_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    logic              accept;
    logic              free_found;
    logic [4:0]        free_slot;
    logic              rem_gt;
    logic [15:0]       rem_sub;
    logic [15:0]       secs;
    logic [24:0]       bytes_m1_full;
    logic              count_bad;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
        begin
            if (!req.busy_slots[s])
            begin
                free_found = 1'b1;
                free_slot  = 5'(s);
            end
        end
    end

    // shared remaining-count unit
    assign rem_gt        = rem_reg > SPE;
    assign rem_sub       = rem_gt ? (rem_reg - SPE) : 16'd0;
    assign secs          = rem_gt ? SPE : rem_reg;
    assign bytes_m1_full = {secs, 9'd0} - 25'd1;
    assign count_bad     = (count_reg == 16'd0) || (count_reg > SECTOR_LIMIT);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        ent_next   = ent_reg;
        idx_next   = idx_reg;
        addr_next  = accept ? req.buffer_address : addr_reg;
        out_load   = 1'b0;
        out_next   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!found_reg || count_bad)
                begin
                    if (out_free)
                    begin
                        out_load        = 1'b1;
                        out_next.status = found_reg ? acdb_pkg::STATUS_BAD_CNT
                                                    : acdb_pkg::STATUS_NO_SLOT;
                        out_next.slot   = found_reg ? slot_reg : 5'd0;
                        out_next.last   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    rem_next   = count_reg;
                    ent_next   = '0;
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                ent_next = ent_reg + 1'b1;
                rem_next = rem_sub;
                if (!rem_gt)
                begin
                    rem_next   = count_reg;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load                     = 1'b1;
                    out_next.status              = acdb_pkg::STATUS_OK;
                    out_next.slot                = slot_reg;
                    out_next.write_dir           = dir_reg;
                    out_next.ata_command         = dir_reg ? acdb_pkg::ATA_WRITE_DMA_EXT
                                                           : acdb_pkg::ATA_READ_DMA_EXT;
                    out_next.entry_total         = 4'(ent_reg);
                    out_next.entry_index         = 3'(idx_reg);
                    out_next.data_address        = addr_reg;
                    out_next.byte_count_less_one = bytes_m1_full[acdb_pkg::BYTE_COUNT_W-1:0];
                    out_next.irq_on_done         = !rem_gt;
                    out_next.fis_lba             = lba_reg;
                    out_next.fis_count           = count_reg;
                    out_next.last                = !rem_gt;
                    rem_next                     = rem_sub;
                    idx_next                     = idx_reg + 1'b1;
                    addr_next                    = addr_reg + STRIDE;
                    if (!rem_gt)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dir_reg   <= req.cmd;
            lba_reg   <= req.lba;
            count_reg <= req.sector_count;
            slot_reg  <= free_slot;
            found_reg <= free_found;
        end
        if (out_load)
        begin
            out_reg <= out_next;
        end
        addr_reg <= addr_next;
        rem_reg  <= rem_next;
        ent_reg  <= ent_next;
        idx_reg  <= idx_next;
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.status              = out_reg.status;
    assign rsp.slot                = out_reg.slot;
    assign rsp.write_dir           = out_reg.write_dir;
    assign rsp.ata_command         = out_reg.ata_command;
    assign rsp.entry_total         = out_reg.entry_total;
    assign rsp.entry_index         = out_reg.entry_index;
    assign rsp.data_address        = out_reg.data_address;
    assign rsp.byte_count_less_one = out_reg.byte_count_less_one;
    assign rsp.irq_on_done         = out_reg.irq_on_done;
    assign rsp.fis_lba             = out_reg.fis_lba;
    assign rsp.fis_count           = out_reg.fis_count;
    assign rsp.last                = out_reg.last;

endmodule

@@ design/acdb_checker.sv @@
// port-level checks for the command descriptor builder, bound to the top level
module acdb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  logic [1:0]  rsp_status,
    input  logic [4:0]  rsp_slot,
    input  logic [31:0] rsp_data_address,
    input  logic        rsp_irq_on_done,
    input  logic [15:0] rsp_fis_count,
    input  logic        rsp_last
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_address)
                                    && $stable(rsp_last))
        else $error("stalled rsp word changed");

    // an error word closes its command
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != acdb_pkg::STATUS_OK |-> rsp_last && !rsp_irq_on_done)
        else $error("error word not last or carries irq");

    // interrupt flag only on the closing entry
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == acdb_pkg::STATUS_OK |-> rsp_irq_on_done == rsp_last)
        else $error("irq flag and last disagree");

    // no-slot word carries no slot and no count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == acdb_pkg::STATUS_NO_SLOT |->
            rsp_slot == 5'd0 && rsp_fis_count == 16'd0)
        else $error("no-slot word has stray fields");

endmodule

bind ahci_command_descriptor_builder_unit acdb_checker u_acdb_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_slot         (rsp.slot),
    .rsp_data_address (rsp.data_address),
    .rsp_irq_on_done  (rsp.irq_on_done),
    .rsp_fis_count    (rsp.fis_count),
    .rsp_last         (rsp.last)
);

@@ tb/tb_ahci_command_descriptor_builder_unit.sv @@
// testbench for the command descriptor builder: slot choice and scatter-gather entry checks
`timescale 1ns / 1ps

module tb_ahci_command_descriptor_builder_unit;

    localparam int MAX_ENTRIES       = 8;
    localparam int SECTORS_PER_ENTRY = 16;
    localparam int NUM_SLOTS         = 32;
    localparam int ENTRY_STRIDE      = SECTORS_PER_ENTRY * acdb_pkg::SECTOR_BYTES;
    localparam int RANDOM_CMDS       = 250;
    localparam int TAIL_CMDS         = 30;
    localparam int DRAIN_CYCLES      = 40;
    localparam int CYCLE_LIMIT       = 400000;

    typedef struct {
        logic        cmd;
        logic [47:0] lba;
        logic [15:0] sector_count;
        logic [31:0] buffer_address;
        logic [31:0] busy_slots;
    } command_t;

    typedef struct {
        acdb_pkg::status_t status;
        logic [4:0]  slot;
        logic        write_dir;
        logic [7:0]  ata_command;
        logic [3:0]  entry_total;
        logic [2:0]  entry_index;
        logic [31:0] data_address;
        logic [12:0] byte_count_less_one;
        logic        irq_on_done;
        logic [47:0] fis_lba;
        logic [15:0] fis_count;
        logic        last;
    } sg_entry_t;

    logic clk = 1'b0;
    logic rst_n;

    acdb_req_if req_bus ();
    acdb_rsp_if rsp_bus ();

    ahci_command_descriptor_builder_unit #(
        .MAX_ENTRIES       (MAX_ENTRIES),
        .SECTORS_PER_ENTRY (SECTORS_PER_ENTRY),
        .NUM_SLOTS         (NUM_SLOTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    command_t  pending_cmds[$];
    sg_entry_t expected_entries[$];
    command_t  cur_cmd;
    int        total_cmds = 0;
    int        accepted_cnt = 0;
    int        checked_cnt = 0;
    int        mismatch_cnt = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    int        cycle_cnt = 0;

    function automatic void predict_entries(command_t c);
        sg_entry_t e;
        int        free_slot;
        int        n_entries;
        int        left;
        int        secs;
        logic [31:0] addr;

        e = '{status: acdb_pkg::STATUS_OK, default: '0};
        e.status = acdb_pkg::STATUS_OK;
        free_slot = -1;
        for (int s = NUM_SLOTS - 1; s >= 0; s--)
            if (!c.busy_slots[s])
                free_slot = s;

        if (free_slot < 0)
        begin
            e.status = acdb_pkg::STATUS_NO_SLOT;
            e.last = 1'b1;
            expected_entries.push_back(e);
            return;
        end

        n_entries = (c.sector_count == 0) ? 0
                  : (int'(c.sector_count) - 1) / SECTORS_PER_ENTRY + 1;
        e.slot = free_slot[4:0];
        if (n_entries == 0 || n_entries > MAX_ENTRIES)
        begin
            e.status = acdb_pkg::STATUS_BAD_CNT;
            e.last = 1'b1;
            expected_entries.push_back(e);
            return;
        end

        left = int'(c.sector_count);
        addr = c.buffer_address;
        for (int k = 0; k < n_entries; k++)
        begin
            secs = (k == n_entries - 1) ? left : SECTORS_PER_ENTRY;
            e.write_dir           = c.cmd;
            e.ata_command         = c.cmd ? acdb_pkg::ATA_WRITE_DMA_EXT
                                          : acdb_pkg::ATA_READ_DMA_EXT;
            e.entry_total         = n_entries[3:0];
            e.entry_index         = k[2:0];
            e.data_address        = addr;
            e.byte_count_less_one = 13'(secs * acdb_pkg::SECTOR_BYTES - 1);
            e.irq_on_done         = (k == n_entries - 1);
            e.fis_lba             = c.lba;
            e.fis_count           = c.sector_count;
            e.last                = (k == n_entries - 1);
            expected_entries.push_back(e);
            addr = addr + 32'(ENTRY_STRIDE);
            left = left - secs;
        end
    endfunction

    function automatic string field_diff(string name, logic [47:0] want, logic [47:0] got);
        if (got !== want)
            return $sformatf(" %s exp %0h got %0h", name, want, got);
        return "";
    endfunction

    task automatic add_command(logic cmd, logic [47:0] lba, logic [15:0] count,
                               logic [31:0] addr, logic [31:0] busy);
        command_t c;
        c.cmd            = cmd;
        c.lba            = lba;
        c.sector_count   = count;
        c.buffer_address = addr;
        c.busy_slots     = busy;
        pending_cmds.push_back(c);
        total_cmds++;
    endtask

    task automatic add_random_command();
        logic [31:0] busy;
        logic [31:0] addr;
        logic [15:0] count;
        int          pick;
        int          free_bit;

        pick = $urandom_range(0, 9);
        free_bit = $urandom_range(0, 31);
        busy = ($urandom() & ~(32'h1 << free_bit)) | ((32'h1 << free_bit) - 32'h1);
        addr = ($urandom_range(0, 7) == 0) ? (32'hFFFF_0000 | $urandom_range(0, 16'hFFFF))
                                           : $urandom();
        case ($urandom_range(0, 3))
            0:       count = 16'(SECTORS_PER_ENTRY * $urandom_range(1, MAX_ENTRIES));
            1:       count = 16'(SECTORS_PER_ENTRY * $urandom_range(0, MAX_ENTRIES - 1) + 1);
            default: count = 16'($urandom_range(1, SECTORS_PER_ENTRY * MAX_ENTRIES));
        endcase
        if (pick == 0)
            busy = 32'hFFFF_FFFF;
        else if (pick == 1)
            count = ($urandom_range(0, 3) == 0) ? 16'h0000
                  : 16'($urandom_range(SECTORS_PER_ENTRY * MAX_ENTRIES + 1, 16'hFFFF));
        add_command(1'($urandom_range(0, 1)), 48'({$urandom(), $urandom()}), count, addr,
                    busy);
    endtask

    wire tail_phase = (total_cmds - accepted_cnt) <= TAIL_CMDS;

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_bus.valid          <= 1'b0;
            req_bus.cmd            <= 1'b0;
            req_bus.lba            <= '0;
            req_bus.sector_count   <= '0;
            req_bus.buffer_address <= '0;
            req_bus.busy_slots     <= '0;
            gap_left = 0;
        end
        else if (!req_bus.valid || req_bus.ready)
        begin
            if (req_bus.valid)
            begin
                predict_entries(cur_cmd);
                accepted_cnt++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_bus.valid <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                cur_cmd = pending_cmds.pop_front();
                req_bus.valid          <= 1'b1;
                req_bus.cmd            <= cur_cmd.cmd;
                req_bus.lba            <= cur_cmd.lba;
                req_bus.sector_count   <= cur_cmd.sector_count;
                req_bus.buffer_address <= cur_cmd.buffer_address;
                req_bus.busy_slots     <= cur_cmd.busy_slots;
                if (!tail_phase && (accepted_cnt / 50) % 3 != 2
                        && $urandom_range(0, 4) == 0)
                    gap_left = $urandom_range(1, 17);
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        sg_entry_t want;
        string     diffs;

        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                checked_cnt++;
                if (expected_entries.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: status %0d slot %0d last %0b",
                                 rsp_bus.status, rsp_bus.slot, rsp_bus.last);
                end
                else
                begin
                    want = expected_entries.pop_front();
                    diffs = {field_diff("status", want.status, rsp_bus.status),
                             field_diff("slot", want.slot, rsp_bus.slot),
                             field_diff("write_dir", want.write_dir, rsp_bus.write_dir),
                             field_diff("ata_command", want.ata_command, rsp_bus.ata_command),
                             field_diff("entry_total", want.entry_total, rsp_bus.entry_total),
                             field_diff("entry_index", want.entry_index, rsp_bus.entry_index),
                             field_diff("data_address", want.data_address,
                                        rsp_bus.data_address),
                             field_diff("byte_count_less_one", want.byte_count_less_one,
                                        rsp_bus.byte_count_less_one),
                             field_diff("irq_on_done", want.irq_on_done, rsp_bus.irq_on_done),
                             field_diff("fis_lba", want.fis_lba, rsp_bus.fis_lba),
                             field_diff("fis_count", want.fis_count, rsp_bus.fis_count),
                             field_diff("last", want.last, rsp_bus.last)};
                    if (diffs != "")
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch on word %0d:%s", checked_cnt, diffs);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!tail_phase && (checked_cnt / 60) % 3 != 1
                     && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 17) - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
            begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        // directed: field extremes, slot search, entry sizing, error cases
        add_command(1'b0, 48'h0, 16'd1, 32'h0, 32'h0);
        add_command(1'b1, 48'hFFFF_FFFF_FFFF, 16'd16, 32'hFFFF_FFFF, 32'h1);
        add_command(1'b0, 48'h1234_5678_9ABC, 16'd17, 32'h1000_0000, 32'h3);
        add_command(1'b1, 48'h0000_0000_0001, 16'd128, 32'hFFFF_E000, 32'h7FFF_FFFF);
        add_command(1'b0, 48'h0, 16'd129, 32'h0, 32'h0000_FFFF);
        add_command(1'b1, 48'hFFFF_FFFF_FFFF, 16'd0, 32'hFFFF_FFFF, 32'h0);
        add_command(1'b0, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        add_command(1'b1, 48'hABCD_EF01_2345, 16'd5, 32'h8000_0000, 32'hFFFF_FFFF);
        add_command(1'b0, 48'h0, 16'd0, 32'h0, 32'hFFFF_FFFF);
        add_command(1'b1, 48'h7FFF_FFFF_FFFF, 16'd127, 32'hFFFF_F000, 32'hBFFF_FFFF);
        add_command(1'b0, 48'h8000_0000_0000, 16'd113, 32'h0000_0200, 32'h0000_00FF);
        add_command(1'b1, 48'h5555_5555_5555, 16'd15, 32'h5555_5555, 32'hAAAA_AAAA);
        add_command(1'b0, 48'hAAAA_AAAA_AAAA, 16'd64, 32'hAAAA_AAAA, 32'h5555_5555);
        add_command(1'b1, 48'h0, 16'h8000, 32'h0, 32'h0);
        add_command(1'b0, 48'h0000_FFFF_0000, 16'd32, 32'h0000_FFFF, 32'h8000_0000);
        add_command(1'b1, 48'hFFFF_0000_FFFF, 16'd96, 32'hFFFF_0000, 32'hFFFF_0000);
        add_command(1'b0, 48'h0, 16'd144, 32'h0, 32'h0000_0001);

        for (int i = 0; i < RANDOM_CMDS; i++)
            add_random_command();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt < total_cmds || expected_entries.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_cnt == 0 && expected_entries.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
